### hw/rtl/rlbf_pkg.sv
// shared constants, command and status types for the relatedness log bayes factor block
package rlbf_pkg;

  localparam int FRAC    = 16;
  localparam int COUNT_W = 24;
  localparam int QW      = FRAC + 1;
  localparam int AW      = FRAC + 8;
  localparam int BW      = FRAC + 3;
  localparam int LOGW    = FRAC + 6;
  localparam int MAGW    = FRAC + 5;
  localparam int ACC_W   = 48;
  localparam int OUT_W   = 32;
  localparam int IDX_W   = 3;
  localparam int NUM_REGS = 7;
  localparam int IN_TD_W  = 160;
  localparam int OUT_TD_W = 56;

  localparam logic [QW-1:0] ONE     = QW'(1) << FRAC;
  localparam logic [QW-1:0] ERR_RST = QW'((66 << FRAC) >> 16);
  localparam logic [31:0]   LN2_Q32 = 32'd2977044472;

  localparam logic [IDX_W-1:0] REG_ERR   = 3'd0;
  localparam logic [IDX_W-1:0] REG_NULL0 = 3'd1;
  localparam logic [IDX_W-1:0] REG_NULL1 = 3'd2;
  localparam logic [IDX_W-1:0] REG_NULL2 = 3'd3;
  localparam logic [IDX_W-1:0] REG_ALT0  = 3'd4;
  localparam logic [IDX_W-1:0] REG_ALT1  = 3'd5;
  localparam logic [IDX_W-1:0] REG_ALT2  = 3'd6;

  // power and product steps of the frequency terms, in dependency order
  localparam logic [3:0] P_PA2    = 4'd0;
  localparam logic [3:0] P_PA3    = 4'd1;
  localparam logic [3:0] P_PA4    = 4'd2;
  localparam logic [3:0] P_PB2    = 4'd3;
  localparam logic [3:0] P_PB3    = 4'd4;
  localparam logic [3:0] P_PB4    = 4'd5;
  localparam logic [3:0] P_PAPB   = 4'd6;
  localparam logic [3:0] P_PA3PB  = 4'd7;
  localparam logic [3:0] P_PA2PB  = 4'd8;
  localparam logic [3:0] P_PA2PB2 = 4'd9;
  localparam logic [3:0] P_PAPB3  = 4'd10;
  localparam logic [3:0] P_PAPB2  = 4'd11;
  localparam int         NUM_POW  = 12;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_POW, OP_FILL, OP_PAIR, OP_COL,
    OP_MODEL, OP_MIX, OP_LN_A, OP_LN_N, OP_ACC, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx;
    logic [1:0] ga;
    logic [1:0] gb;
    logic [1:0] k;
    logic       sel;
  } cmd_t;

  typedef struct packed {
    logic known;
    logic last;
    logic ln_done;
    logic out_full;
  } stat_t;

  typedef struct packed {
    logic [QW-1:0] allele_freq;
    logic          freq_known;
    logic [QW-1:0] a_prob_g0;
    logic [QW-1:0] a_prob_g1;
    logic [QW-1:0] a_prob_g2;
    logic [QW-1:0] a_null_prob;
    logic [QW-1:0] b_prob_g0;
    logic [QW-1:0] b_prob_g1;
    logic [QW-1:0] b_prob_g2;
    logic [QW-1:0] b_null_prob;
    logic          last_site;
  } site_t;

  function automatic logic [QW-1:0] clamp_one(input logic [QW-1:0] v);
    clamp_one = (v > ONE) ? ONE : v;
  endfunction

endpackage

### hw/rtl/rlbf_ln.sv
// iterative natural log unit: normalise, bitwise log2 by squaring, scale by ln2
module rlbf_ln (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [rlbf_pkg::AW-1:0]            x,
  output logic                               done,
  output logic signed [rlbf_pkg::LOGW-1:0]   result
);
  import rlbf_pkg::*;

  localparam int KW = $clog2(AW);
  localparam int IW = $clog2(FRAC);

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_SCALE, L_RND, L_DONE} lstate_t;

  lstate_t                   state_r;
  logic [AW-1:0]             x_r;
  logic [KW-1:0]             k_r;
  logic [QW-1:0]             m_r;
  logic [IW-1:0]             it_r;
  logic [FRAC-1:0]           y_r;
  logic                      neg_r;
  logic [MAGW+31:0]          prod_r;
  logic signed [LOGW-1:0]    result_r;

  logic [2*QW-1:0]           sq_full;
  logic [QW:0]               sq;
  logic signed [LOGW-1:0]    lg;
  logic [MAGW-1:0]           mag;
  logic [MAGW+32:0]          rnd_full;
  logic [MAGW-1:0]           rnd;

  always_comb begin
    sq_full  = {{QW{1'b0}}, m_r} * {{QW{1'b0}}, m_r};
    sq       = sq_full[FRAC +: QW+1];
    lg       = (($signed(LOGW'(k_r)) - $signed(LOGW'(FRAC))) <<< FRAC)
               + $signed(LOGW'(y_r));
    mag      = lg[LOGW-1] ? MAGW'(-lg) : MAGW'(lg);
    rnd_full = {1'b0, prod_r} + (MAGW+33)'(64'h8000_0000);
    rnd      = rnd_full[32 +: MAGW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      case (state_r)
        L_IDLE: begin
          if (start) begin
            x_r     <= x;
            k_r     <= KW'(AW - 1);
            state_r <= L_NORM;
          end
        end
        L_NORM: begin
          if (x_r[AW-1] || k_r == '0) begin
            m_r     <= x_r[AW-1 -: QW];
            it_r    <= '0;
            y_r     <= '0;
            state_r <= L_SQ;
          end else begin
            x_r <= x_r << 1;
            k_r <= k_r - 1'b1;
          end
        end
        L_SQ: begin
          if (sq[QW]) begin
            m_r <= sq[QW:1];
            y_r <= {y_r[FRAC-2:0], 1'b1};
          end else begin
            m_r <= sq[QW-1:0];
            y_r <= {y_r[FRAC-2:0], 1'b0};
          end
          it_r <= it_r + 1'b1;
          if (it_r == IW'(FRAC - 1)) state_r <= L_SCALE;
        end
        L_SCALE: begin
          neg_r   <= lg[LOGW-1];
          prod_r  <= {32'd0, mag} * {{MAGW{1'b0}}, LN2_Q32};
          state_r <= L_RND;
        end
        L_RND: begin
          result_r <= neg_r ? -$signed(LOGW'(rnd)) : $signed(LOGW'(rnd));
          state_r  <= L_DONE;
        end
        L_DONE:  state_r <= L_IDLE;
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done   = (state_r == L_DONE);
  assign result = result_r;

endmodule

### hw/rtl/rlbf_ctrl.sv
// sequencer that steps the shared multiplier, log unit and accumulator through one site
module rlbf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  rlbf_pkg::stat_t st,
  output rlbf_pkg::cmd_t  cmd
);
  import rlbf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_POW, S_FILL, S_PAIR, S_COL, S_MODEL, S_MIX,
    S_LNA, S_LNA_W, S_LNN, S_LNN_W, S_ACC, S_EMIT
  } state_t;

  state_t     state_r;
  logic [3:0] idx_r;
  logic [1:0] ga_r, gb_r, k_r;
  logic       sel_r;

  always_comb begin
    cmd     = '0;
    cmd.op  = OP_NONE;
    cmd.idx = idx_r;
    cmd.ga  = ga_r;
    cmd.gb  = gb_r;
    cmd.k   = k_r;
    cmd.sel = sel_r;
    case (state_r)
      S_IDLE:  cmd.op = in_tvalid ? OP_LOAD : OP_NONE;
      S_POW:   cmd.op = OP_POW;
      S_FILL:  cmd.op = OP_FILL;
      S_PAIR:  cmd.op = OP_PAIR;
      S_COL:   cmd.op = OP_COL;
      S_MODEL: cmd.op = OP_MODEL;
      S_MIX:   cmd.op = OP_MIX;
      S_LNA:   cmd.op = OP_LN_A;
      S_LNN:   cmd.op = OP_LN_N;
      S_ACC:   cmd.op = OP_ACC;
      S_EMIT:  cmd.op = st.out_full ? OP_NONE : OP_EMIT;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      ga_r    <= '0;
      gb_r    <= '0;
      k_r     <= '0;
      sel_r   <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            idx_r   <= '0;
            state_r <= S_POW;
          end
        end
        S_POW: begin
          if (!st.known) begin
            state_r <= S_ACC;
          end else if (idx_r == 4'(NUM_POW - 1)) begin
            ga_r    <= '0;
            sel_r   <= 1'b0;
            state_r <= S_FILL;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_FILL: begin
          // ga walks the genotype, sel picks the sample
          if (ga_r == 2'd2) begin
            ga_r <= '0;
            if (sel_r) begin
              gb_r    <= '0;
              sel_r   <= 1'b0;
              state_r <= S_PAIR;
            end else begin
              sel_r <= 1'b1;
            end
          end else begin
            ga_r <= ga_r + 1'b1;
          end
        end
        S_PAIR: begin
          k_r     <= '0;
          state_r <= S_COL;
        end
        S_COL: begin
          if (k_r == 2'd2) begin
            k_r <= '0;
            if (gb_r == 2'd2) begin
              gb_r <= '0;
              if (ga_r == 2'd2) begin
                sel_r   <= 1'b0;
                state_r <= S_MODEL;
              end else begin
                ga_r    <= ga_r + 1'b1;
                state_r <= S_PAIR;
              end
            end else begin
              gb_r    <= gb_r + 1'b1;
              state_r <= S_PAIR;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_MODEL: begin
          if (k_r == 2'd2) state_r <= S_MIX;
          else k_r <= k_r + 1'b1;
        end
        S_MIX: begin
          k_r <= '0;
          if (sel_r) begin
            state_r <= S_LNA;
          end else begin
            sel_r   <= 1'b1;
            state_r <= S_MODEL;
          end
        end
        S_LNA:   state_r <= S_LNA_W;
        S_LNA_W: if (st.ln_done) state_r <= S_LNN;
        S_LNN:   state_r <= S_LNN_W;
        S_LNN_W: if (st.ln_done) state_r <= S_ACC;
        S_ACC:   state_r <= st.last ? S_EMIT : S_IDLE;
        S_EMIT:  if (!st.out_full) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/rlbf_dp.sv
// datapath: config registers, shared q-multiplier, likelihood terms, log unit, accumulator
module rlbf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rlbf_pkg::cmd_t                    cmd,
  output rlbf_pkg::stat_t                   st,
  input  rlbf_pkg::site_t                   site,
  input  logic                              cfg_we,
  input  logic [rlbf_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rlbf_pkg::QW-1:0]           cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [rlbf_pkg::OUT_W-1:0] out_lbf,
  output logic [rlbf_pkg::COUNT_W-1:0]      out_sites,
  output logic                              out_sat
);
  import rlbf_pkg::*;

  localparam int PW = AW + BW;
  localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC - 1);

  logic [QW-1:0]             cfg_r [NUM_REGS];
  site_t                     site_r;
  logic [QW-1:0]             pa_r, pb_r;
  logic [QW-1:0]             pw_r  [NUM_POW];
  logic [QW-1:0]             pa_g_r[3];
  logic [QW-1:0]             pb_g_r[3];
  logic [QW-1:0]             pair_r;
  logic [AW-1:0]             col_r [3];
  logic [AW-1:0]             v_r, la_r, ln_r;
  logic signed [LOGW-1:0]    lna_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [COUNT_W-1:0]        cnt_r;
  logic                      ovf_r;
  logic                      out_valid_r;
  logic signed [OUT_W-1:0]   out_lbf_r;
  logic [COUNT_W-1:0]        out_sites_r;
  logic                      out_sat_r;

  logic [AW-1:0]             mul_a;
  logic [BW-1:0]             mul_b;
  logic [PW-1:0]             mul_p;
  logic [AW-1:0]             mul_q;
  logic [BW-1:0]             mat_v;
  logic [BW-1:0]             hwe_v;
  logic [QW-1:0]             w_v, e_v, g_v;
  logic [AW-1:0]             fill_s, mix_s;
  logic [2:0]                gsum;
  logic                      ln_start, ln_done;
  logic [AW-1:0]             ln_x;
  logic signed [LOGW-1:0]    ln_res;
  logic signed [LOGW:0]      diff;
  logic signed [ACC_W:0]     acc_s;

  assign e_v  = clamp_one(cfg_r[REG_ERR]);
  assign gsum = {1'b0, cmd.ga} + {1'b0, cmd.gb};

  // genotype-pair by ibd-state matrix entry for the current row and column
  always_comb begin
    mat_v = '0;
    case (gsum)
      3'd0: begin
        case (cmd.k)
          2'd0:    mat_v = BW'(pw_r[P_PA4]);
          2'd1:    mat_v = BW'(pw_r[P_PA3]);
          default: mat_v = BW'(pw_r[P_PA2]);
        endcase
      end
      3'd1: begin
        case (cmd.k)
          2'd0:    mat_v = BW'({pw_r[P_PA3PB], 1'b0});
          2'd1:    mat_v = BW'(pw_r[P_PA2PB]);
          default: mat_v = '0;
        endcase
      end
      3'd2: begin
        if (cmd.ga == 2'd1) begin
          case (cmd.k)
            2'd0:    mat_v = BW'({pw_r[P_PA2PB2], 2'b00});
            2'd1:    mat_v = BW'(pw_r[P_PAPB]);
            default: mat_v = BW'({pw_r[P_PAPB], 1'b0});
          endcase
        end else begin
          mat_v = (cmd.k == 2'd0) ? BW'(pw_r[P_PA2PB2]) : '0;
        end
      end
      3'd3: begin
        case (cmd.k)
          2'd0:    mat_v = BW'({pw_r[P_PAPB3], 1'b0});
          2'd1:    mat_v = BW'(pw_r[P_PAPB2]);
          default: mat_v = '0;
        endcase
      end
      default: begin
        case (cmd.k)
          2'd0:    mat_v = BW'(pw_r[P_PB4]);
          2'd1:    mat_v = BW'(pw_r[P_PB3]);
          default: mat_v = BW'(pw_r[P_PB2]);
        endcase
      end
    endcase
  end

  // hardy-weinberg fill and per-genotype probability
  always_comb begin
    case (cmd.ga)
      2'd0:    hwe_v = BW'(pw_r[P_PA2]);
      2'd1:    hwe_v = BW'({pw_r[P_PAPB], 1'b0});
      default: hwe_v = BW'(pw_r[P_PB2]);
    endcase
    case ({cmd.sel, cmd.ga})
      3'b000:  g_v = site_r.a_prob_g0;
      3'b001:  g_v = site_r.a_prob_g1;
      3'b010:  g_v = site_r.a_prob_g2;
      3'b100:  g_v = site_r.b_prob_g0;
      3'b101:  g_v = site_r.b_prob_g1;
      default: g_v = site_r.b_prob_g2;
    endcase
  end

  // model prior: sel low is the alternative, high the null
  always_comb begin
    case ({cmd.sel, cmd.k})
      3'b000:  w_v = cfg_r[REG_ALT0];
      3'b001:  w_v = cfg_r[REG_ALT1];
      3'b010:  w_v = cfg_r[REG_ALT2];
      3'b100:  w_v = cfg_r[REG_NULL0];
      3'b101:  w_v = cfg_r[REG_NULL1];
      default: w_v = cfg_r[REG_NULL2];
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_POW: begin
        case (cmd.idx)
          P_PA2:    begin mul_a = AW'(pa_r);            mul_b = BW'(pa_r); end
          P_PA3:    begin mul_a = AW'(pw_r[P_PA2]);     mul_b = BW'(pa_r); end
          P_PA4:    begin mul_a = AW'(pw_r[P_PA3]);     mul_b = BW'(pa_r); end
          P_PB2:    begin mul_a = AW'(pb_r);            mul_b = BW'(pb_r); end
          P_PB3:    begin mul_a = AW'(pw_r[P_PB2]);     mul_b = BW'(pb_r); end
          P_PB4:    begin mul_a = AW'(pw_r[P_PB3]);     mul_b = BW'(pb_r); end
          P_PAPB:   begin mul_a = AW'(pa_r);            mul_b = BW'(pb_r); end
          P_PA3PB:  begin mul_a = AW'(pw_r[P_PA3]);     mul_b = BW'(pb_r); end
          P_PA2PB:  begin mul_a = AW'(pw_r[P_PA2]);     mul_b = BW'(pb_r); end
          P_PA2PB2: begin mul_a = AW'(pw_r[P_PA2]);     mul_b = BW'(pw_r[P_PB2]); end
          P_PAPB3:  begin mul_a = AW'(pa_r);            mul_b = BW'(pw_r[P_PB3]); end
          default:  begin mul_a = AW'(pa_r);            mul_b = BW'(pw_r[P_PB2]); end
        endcase
      end
      OP_FILL: begin
        mul_a = AW'(hwe_v);
        mul_b = BW'(clamp_one(cmd.sel ? site_r.b_null_prob : site_r.a_null_prob));
      end
      OP_PAIR: begin
        mul_a = AW'(pa_g_r[cmd.ga]);
        mul_b = BW'(pb_g_r[cmd.gb]);
      end
      OP_COL: begin
        mul_a = AW'(pair_r);
        mul_b = mat_v;
      end
      OP_MODEL: begin
        mul_a = col_r[cmd.k];
        mul_b = BW'(clamp_one(w_v));
      end
      OP_MIX: begin
        mul_a = v_r;
        mul_b = BW'(ONE - e_v);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = {{BW{1'b0}}, mul_a} * {{AW{1'b0}}, mul_b} + HALF_P;
    mul_q = mul_p[FRAC +: AW];
  end

  assign fill_s = AW'(clamp_one(g_v)) + mul_q;
  assign mix_s  = mul_q + AW'(e_v);

  assign ln_start = (cmd.op == OP_LN_A) || (cmd.op == OP_LN_N);
  assign ln_x     = (cmd.op == OP_LN_A) ? la_r : ln_r;

  rlbf_ln u_ln (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ln_start),
    .x      (ln_x),
    .done   (ln_done),
    .result (ln_res)
  );

  assign diff  = $signed({lna_r[LOGW-1], lna_r}) - $signed({ln_res[LOGW-1], ln_res});
  assign acc_s = $signed({acc_r[ACC_W-1], acc_r}) + $signed((ACC_W+1)'(diff));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_ERR]   <= ERR_RST;
      cfg_r[REG_NULL0] <= ONE;
      cfg_r[REG_NULL1] <= '0;
      cfg_r[REG_NULL2] <= '0;
      cfg_r[REG_ALT0]  <= '0;
      cfg_r[REG_ALT1]  <= ONE;
      cfg_r[REG_ALT2]  <= '0;
      acc_r            <= '0;
      cnt_r            <= '0;
      ovf_r            <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we && cfg_index < IDX_W'(NUM_REGS)) cfg_r[cfg_index] <= cfg_wdata;
      if (cmd.op == OP_EMIT) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: begin
          site_r <= site;
          pb_r   <= clamp_one(site.allele_freq);
          pa_r   <= ONE - clamp_one(site.allele_freq);
        end
        OP_POW: pw_r[cmd.idx] <= QW'(mul_q);
        OP_FILL: begin
          if (cmd.sel) pb_g_r[cmd.ga] <= (fill_s > AW'(ONE)) ? ONE : QW'(fill_s);
          else         pa_g_r[cmd.ga] <= (fill_s > AW'(ONE)) ? ONE : QW'(fill_s);
        end
        OP_PAIR: pair_r <= QW'(mul_q);
        OP_COL: begin
          if (cmd.ga == 2'd0 && cmd.gb == 2'd0) col_r[cmd.k] <= mul_q;
          else col_r[cmd.k] <= col_r[cmd.k] + mul_q;
        end
        OP_MODEL: v_r <= (cmd.k == 2'd0) ? mul_q : v_r + mul_q;
        OP_MIX: begin
          // a likelihood of zero becomes one lsb so the log stays finite
          if (cmd.sel) ln_r <= (mix_s == '0) ? AW'(1) : mix_s;
          else         la_r <= (mix_s == '0) ? AW'(1) : mix_s;
          if (mix_s == '0) ovf_r <= 1'b1;
        end
        OP_LN_N: lna_r <= ln_res;
        OP_ACC: begin
          if (site_r.freq_known) begin
            if (acc_s[ACC_W] != acc_s[ACC_W-1]) begin
              acc_r <= acc_s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
              ovf_r <= 1'b1;
            end else begin
              acc_r <= acc_s[ACC_W-1:0];
            end
            if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
          end
        end
        OP_EMIT: begin
          out_sites_r <= cnt_r;
          if (!acc_r[ACC_W-1] && (|acc_r[ACC_W-2:OUT_W-1])) begin
            out_lbf_r <= {1'b0, {(OUT_W-1){1'b1}}};
            out_sat_r <= 1'b1;
          end else if (acc_r[ACC_W-1] && !(&acc_r[ACC_W-2:OUT_W-1])) begin
            out_lbf_r <= {1'b1, {(OUT_W-1){1'b0}}};
            out_sat_r <= 1'b1;
          end else begin
            out_lbf_r <= acc_r[OUT_W-1:0];
            out_sat_r <= ovf_r;
          end
          acc_r <= '0;
          cnt_r <= '0;
          ovf_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign st.known    = site_r.freq_known;
  assign st.last     = site_r.last_site;
  assign st.ln_done  = ln_done;
  assign st.out_full = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_lbf   = out_lbf_r;
  assign out_sites = out_sites_r;
  assign out_sat   = out_sat_r;

endmodule

### hw/rtl/relatedness_log_bayes_factor_top.sv
// top level of the pairwise relatedness log bayes factor block
//
//  channel | direction | transfer carries
//  in_     | slave     | one variant site: frequency, known flag, two samples' genotype masses
//  out_    | master    | log bayes factor, sites used, saturated flag, one per last site
//  cfg_    | write     | error probability and the six ibd priors
//
// one site at a time: a known-frequency site runs 62 steps of the shared multiplier
// plus two passes of the iterative log unit (up to 23 normalise shifts and 16
// squarings each); an unknown site goes from the first power step straight to
// the accumulate step. reset is synchronous and clears the sums and loads the
// default priors. a stalled output holds its result while the next site is
// taken; a finished pair waits only if the previous result is still held.
module relatedness_log_bayes_factor_top
  import rlbf_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // allele_freq, a_prob_g0, a_prob_g1, a_prob_g2, a_null_prob,
  // b_prob_g0, b_prob_g1, b_prob_g2, b_null_prob
  input  logic [IN_TD_W-1:0]          in_tdata,
  // freq_known
  input  logic                        in_tuser,
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // log_bayes_factor, sites_used
  output logic [OUT_TD_W-1:0]         out_tdata,
  // saturated
  output logic                        out_tuser,
  input  logic                        cfg_we,
  input  logic [IDX_W-1:0]            cfg_index,
  input  logic [QW-1:0]               cfg_wdata
);

  cmd_t                    cmd;
  stat_t                   st;
  site_t                   site;
  logic signed [OUT_W-1:0] lbf;
  logic [COUNT_W-1:0]      sites;

  assign site.allele_freq = in_tdata[0*QW +: QW];
  assign site.a_prob_g0   = in_tdata[1*QW +: QW];
  assign site.a_prob_g1   = in_tdata[2*QW +: QW];
  assign site.a_prob_g2   = in_tdata[3*QW +: QW];
  assign site.a_null_prob = in_tdata[4*QW +: QW];
  assign site.b_prob_g0   = in_tdata[5*QW +: QW];
  assign site.b_prob_g1   = in_tdata[6*QW +: QW];
  assign site.b_prob_g2   = in_tdata[7*QW +: QW];
  assign site.b_null_prob = in_tdata[8*QW +: QW];
  assign site.freq_known  = in_tuser;
  assign site.last_site   = in_tlast;

  rlbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  rlbf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .site      (site),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_lbf   (lbf),
    .out_sites (sites),
    .out_sat   (out_tuser)
  );

  assign out_tdata = {sites, lbf};

  // one site in flight: ready drops after every input transfer
  a_one_site: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a site is in flight");

  // a result is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> !(out_tvalid && !out_tready))
    else $error("result overwritten while stalled");

  // the log unit cannot report done the cycle after it is started
  a_ln_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LN_A || cmd.op == OP_LN_N) |=> !st.ln_done)
    else $error("log unit done too early");

endmodule
